/* sv/fscnt_pkg.sv */
`timescale 1ns / 1ps

package fscnt_pkg;

  localparam int TABLE_POINTS = 10;
  localparam int ROM_POINTS   = 10;
  localparam int USED_POINTS  = (TABLE_POINTS > ROM_POINTS) ? ROM_POINTS :
                                (TABLE_POINTS < 2) ? 2 : TABLE_POINTS;
  localparam int SEG_W        = $clog2(USED_POINTS + 1);
  localparam int ROM_IDX_W    = $clog2(ROM_POINTS);

  localparam int FLOW_W      = 16;
  localparam int STEP_W      = 16;
  localparam int DX_W        = 12;
  localparam int DY_W        = 15;
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 31;
  localparam int PROD_W      = 31;
  localparam int QUO_W       = RECIP_W;
  localparam int SUM_W       = QUO_W + 1;

  localparam logic [FLOW_W-1:0] DEFAULT_FLOW = 16'd100;
  localparam logic [STEP_W-1:0] STEP_MAX     = 16'hFFFF;

  typedef logic [FLOW_W-1:0]  flow_arr_t  [ROM_POINTS];
  typedef logic [STEP_W-1:0]  step_arr_t  [ROM_POINTS];
  typedef logic [RECIP_W-1:0] recip_arr_t [ROM_POINTS];

  localparam flow_arr_t FLOW_PT = '{
    16'd5, 16'd10, 16'd25, 16'd50, 16'd100,
    16'd250, 16'd500, 16'd1000, 16'd2500, 16'd5000
  };

  localparam step_arr_t STEP_PT = '{
    16'd59, 16'd117, 16'd283, 16'd585, 16'd1170,
    16'd2925, 16'd5850, 16'd11701, 16'd29252, 16'd58504
  };

  // floor(2^31 / width) of the segment ending at each point; the first
  // segment starts at the origin
  localparam recip_arr_t SEG_RECIP = '{
    29'd429496729, 29'd429496729, 29'd143165576, 29'd85899345, 29'd42949672,
    29'd14316557, 29'd8589934, 29'd4294967, 29'd1431655, 29'd858993
  };

  typedef struct packed {
    logic [FLOW_W-1:0]  d;
    logic [DY_W-1:0]    dy;
    logic [DX_W-1:0]    dx;
    logic [RECIP_W-1:0] recip;
    logic [STEP_W-1:0]  base;
  } seg_t;

  typedef struct packed {
    logic [QUO_W-1:0]  q;
    logic [STEP_W-1:0] base;
  } quo_t;

  // s = number of used points lying below the flow
  function automatic seg_t seg_lookup(input logic [SEG_W-1:0] s,
                                      input logic [FLOW_W-1:0] f);
    seg_t                 res;
    logic                 extrap;
    logic [ROM_IDX_W-1:0] hi;
    logic [ROM_IDX_W-1:0] lo;
    logic [ROM_IDX_W-1:0] anchor;
    logic [FLOW_W-1:0]    dxw;
    logic [STEP_W-1:0]    dyw;
    extrap = (s >= SEG_W'(USED_POINTS));
    hi     = extrap ? ROM_IDX_W'(USED_POINTS - 1) : ROM_IDX_W'(s);
    lo     = hi - ROM_IDX_W'(1);
    anchor = extrap ? hi : lo;
    res.recip = SEG_RECIP[hi];
    if (hi == '0) begin
      res.d    = f;
      res.dx   = FLOW_PT[0][DX_W-1:0];
      res.dy   = STEP_PT[0][DY_W-1:0];
      res.base = '0;
    end else begin
      dxw      = FLOW_PT[hi] - FLOW_PT[lo];
      dyw      = STEP_PT[hi] - STEP_PT[lo];
      res.d    = f - FLOW_PT[anchor];
      res.dx   = dxw[DX_W-1:0];
      res.dy   = dyw[DY_W-1:0];
      res.base = STEP_PT[anchor];
    end
    return res;
  endfunction

endpackage

/* sv/fscnt_if.sv */
`timescale 1ns / 1ps

interface fscnt_in_if;
  logic                         valid;
  logic                         ready;
  logic [fscnt_pkg::FLOW_W-1:0] flow;

  modport source (output valid, output flow, input ready);
  modport sink   (input valid, input flow, output ready);
endinterface

interface fscnt_out_if;
  logic                         valid;
  logic                         ready;
  logic [fscnt_pkg::STEP_W-1:0] step_count;
  logic                         saturated;

  modport source (output valid, output step_count, output saturated, input ready);
  modport sink   (input valid, input step_count, input saturated, output ready);
endinterface

/* sv/fscnt_seg.sv */
`timescale 1ns / 1ps

module fscnt_seg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fscnt_pkg::FLOW_W-1:0] in_flow,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fscnt_pkg::seg_t              out_seg
);
  import fscnt_pkg::*;

  logic              valid_r;
  seg_t              seg_r;
  logic [FLOW_W-1:0] f;
  logic [SEG_W-1:0]  cnt;

  assign f = (in_flow == '0) ? DEFAULT_FLOW : in_flow;

  // table is ascending, so the count of points below f is the segment index
  always_comb begin
    cnt = '0;
    for (int k = 0; k < USED_POINTS; k++) begin
      cnt = cnt + SEG_W'(f > FLOW_PT[k]);
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_seg   = seg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      seg_r <= seg_lookup(cnt, f);
    end
  end

endmodule

/* sv/fscnt_div.sv */
`timescale 1ns / 1ps

// d*dy / dx via reciprocal multiply, back multiply and one correction step
module fscnt_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fscnt_pkg::seg_t in_seg,
  output logic            out_valid,
  input  logic            out_ready,
  output fscnt_pkg::quo_t out_quo
);
  import fscnt_pkg::*;

  // stage a: product
  logic               va_r;
  logic [PROD_W-1:0]  pa_r;
  logic [DX_W-1:0]    dxa_r;
  logic [RECIP_W-1:0] recipa_r;
  logic [STEP_W-1:0]  basea_r;
  // stage b: estimated quotient
  logic               vb_r;
  logic [PROD_W-1:0]  pb_r;
  logic [DX_W-1:0]    dxb_r;
  logic [QUO_W-1:0]   qb_r;
  logic [STEP_W-1:0]  baseb_r;
  // stage c: back product
  logic               vc_r;
  logic [PROD_W-1:0]  pc_r;
  logic [PROD_W-1:0]  qdc_r;
  logic [DX_W-1:0]    dxc_r;
  logic [QUO_W-1:0]   qc_r;
  logic [STEP_W-1:0]  basec_r;
  // stage d: corrected quotient
  logic               vd_r;
  quo_t               quo_r;

  logic rdy_a, rdy_b, rdy_c, rdy_d;

  logic [PROD_W+RECIP_W-1:0] full;
  logic [PROD_W+DX_W-1:0]    back;
  logic [PROD_W-1:0]         rem;
  logic                      corr;

  assign rdy_d = !vd_r || out_ready;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;

  assign in_ready  = rdy_a;
  assign out_valid = vd_r;
  assign out_quo   = quo_r;

  // estimate is q or q-1 since the reciprocal error times p stays below 2^31
  assign full = (PROD_W + RECIP_W)'(pa_r) * (PROD_W + RECIP_W)'(recipa_r);
  assign back = (PROD_W + DX_W)'(qb_r) * (PROD_W + DX_W)'(dxb_r);
  assign rem  = pc_r - qdc_r;
  assign corr = (rem >= PROD_W'(dxc_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      pa_r     <= PROD_W'(in_seg.d) * PROD_W'(in_seg.dy);
      dxa_r    <= in_seg.dx;
      recipa_r <= in_seg.recip;
      basea_r  <= in_seg.base;
    end
    if (rdy_b && va_r) begin
      pb_r    <= pa_r;
      dxb_r   <= dxa_r;
      qb_r    <= full[RECIP_SHIFT +: QUO_W];
      baseb_r <= basea_r;
    end
    if (rdy_c && vb_r) begin
      pc_r    <= pb_r;
      qdc_r   <= back[PROD_W-1:0];
      dxc_r   <= dxb_r;
      qc_r    <= qb_r;
      basec_r <= baseb_r;
    end
    if (rdy_d && vc_r) begin
      quo_r.q    <= qc_r + QUO_W'(corr);
      quo_r.base <= basec_r;
    end
  end

endmodule

/* sv/fscnt_out.sv */
`timescale 1ns / 1ps

module fscnt_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fscnt_pkg::quo_t              in_quo,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fscnt_pkg::STEP_W-1:0] out_step_count,
  output logic                         out_saturated
);
  import fscnt_pkg::*;

  logic              valid_r;
  logic [STEP_W-1:0] step_r;
  logic              sat_r;

  logic [SUM_W-1:0]  sum;
  logic              over;
  logic [STEP_W-1:0] val;

  assign sum  = SUM_W'(in_quo.q) + SUM_W'(in_quo.base);
  assign over = (sum > SUM_W'(STEP_MAX));

  always_comb begin
    if (over) begin
      val = STEP_MAX;
    end else if (sum == '0) begin
      val = STEP_W'(1);
    end else begin
      val = sum[STEP_W-1:0];
    end
  end

  assign in_ready       = !valid_r || out_ready;
  assign out_valid      = valid_r;
  assign out_step_count = step_r;
  assign out_saturated  = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      step_r <= val;
      sat_r  <= over;
    end
  end

endmodule

/* sv/flow_to_step_count_interpolator.sv */
`timescale 1ns / 1ps

// Converts a requested flow into a motor step count by piecewise linear
// interpolation over a fixed ten-point calibration table (the 50 ml table);
// a flow of zero means 100, flows below the first point scale from the
// origin, flows past the last point extrapolate along the last segment,
// and every division floors exactly. The result is at least 1 and
// saturates at 65535 with saturated set. One request per clock is taken
// while the output is not stalled, and each result passes through six
// register stages: the segment lookup, the product, the reciprocal
// multiply, the back multiply, the remainder correction, and the final
// add and clamp. Each stage holds its item when the next one is full, so
// a stalled output only blocks as far back as the pipeline is full.
module flow_to_step_count_interpolator (
  input  logic       clk,
  input  logic       rst_n,
  fscnt_in_if.sink   in_ch,
  fscnt_out_if.source out_ch
);
  import fscnt_pkg::*;

  logic seg_valid, seg_ready;
  seg_t seg;
  logic quo_valid, quo_ready;
  quo_t quo;

  fscnt_seg u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_flow   (in_ch.flow),
    .out_valid (seg_valid),
    .out_ready (seg_ready),
    .out_seg   (seg)
  );

  fscnt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (seg_valid),
    .in_ready  (seg_ready),
    .in_seg    (seg),
    .out_valid (quo_valid),
    .out_ready (quo_ready),
    .out_quo   (quo)
  );

  fscnt_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (quo_valid),
    .in_ready       (quo_ready),
    .in_quo         (quo),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_step_count (out_ch.step_count),
    .out_saturated  (out_ch.saturated)
  );

`ifndef SYNTH
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.step_count != '0)
    else $error("step count of zero presented");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |-> out_ch.step_count == STEP_MAX)
    else $error("saturated without maximum step count");

  a_seg_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> seg_valid)
    else $error("accepted request missing from first stage");
`endif

endmodule
